// File: sv/rc4d_pkg.sv
`default_nettype none
package rc4d_pkg;

  localparam int MAX_KEY_BYTES = 256;
  localparam int PERM_DEPTH    = 256;
  localparam int BYTE_W        = 8;
  localparam int KEY_CNT_W     = 9;
  localparam int DROP_W        = 12;
  localparam logic [DROP_W-1:0] DROP_RESET = 12'd256;

  // microprogram addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_S0   = 4'd1;
  localparam logic [PC_W-1:0] PC_INIT = 4'd2;
  localparam logic [PC_W-1:0] PC_K1   = 4'd3;
  localparam logic [PC_W-1:0] PC_K2   = 4'd4;
  localparam logic [PC_W-1:0] PC_K3   = 4'd5;
  localparam logic [PC_W-1:0] PC_K4   = 4'd6;
  localparam logic [PC_W-1:0] PC_G1   = 4'd7;
  localparam logic [PC_W-1:0] PC_G2   = 4'd8;
  localparam logic [PC_W-1:0] PC_G3   = 4'd9;
  localparam logic [PC_W-1:0] PC_G4   = 4'd10;
  localparam logic [PC_W-1:0] PC_G5   = 4'd11;
  localparam logic [PC_W-1:0] PC_G6   = 4'd12;
  localparam logic [PC_W-1:0] PC_G7   = 4'd13;

  typedef enum logic [2:0] {
    RA_N      = 3'd0,
    RA_IP1    = 3'd1,
    RA_JADD   = 3'd2,
    RA_ACCSUM = 3'd3,
    RA_SUM    = 3'd4
  } rd_addr_t;

  typedef enum logic [1:0] {
    WA_N   = 2'd0,
    WA_I   = 2'd1,
    WA_J   = 2'd2,
    WA_ACC = 2'd3
  } wr_addr_t;

  typedef enum logic [1:0] {
    WD_N     = 2'd0,
    WD_RDATA = 2'd1,
    WD_SI    = 2'd2
  } wr_data_t;

  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,
    C_JUMP      = 3'd1,
    C_DISPATCH  = 3'd2,
    C_N_MORE    = 3'd3,
    C_DROP_MORE = 3'd4
  } cond_t;

  typedef struct packed {
    logic     rd_en;
    rd_addr_t rd_addr;
    logic     key_rd;
    logic     wr_en;
    wr_addr_t wr_addr;
    wr_data_t wr_data;
    logic     clr_sched;
    logic     inc_n;
    logic     acc_add;
    logic     k_adv;
    logic     load_si;
    logic     load_sj;
    logic     j_add;
    logic     inc_i;
    logic     dec_drop;
    logic     emit;
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t          dp;
    cond_t             cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic n_last;
    logic dcnt_zero;
  } dp_status_t;

  typedef struct packed {
    logic go_sched;
    logic go_gen;
  } start_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } ks_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    w.cond   = C_NEXT;
    w.target = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.cond = C_DISPATCH;
      end
      PC_S0: begin
        w.dp.clr_sched = 1'b1;
      end
      PC_INIT: begin
        // identity fill
        w.dp.wr_en   = 1'b1;
        w.dp.wr_addr = WA_N;
        w.dp.wr_data = WD_N;
        w.dp.inc_n   = 1'b1;
        w.cond       = C_N_MORE;
        w.target     = PC_INIT;
      end
      PC_K1: begin
        w.dp.rd_en   = 1'b1;
        w.dp.rd_addr = RA_N;
        w.dp.key_rd  = 1'b1;
      end
      PC_K2: begin
        w.dp.load_si = 1'b1;
        w.dp.acc_add = 1'b1;
        w.dp.k_adv   = 1'b1;
        w.dp.rd_en   = 1'b1;
        w.dp.rd_addr = RA_ACCSUM;
      end
      PC_K3: begin
        w.dp.wr_en   = 1'b1;
        w.dp.wr_addr = WA_N;
        w.dp.wr_data = WD_RDATA;
      end
      PC_K4: begin
        w.dp.wr_en   = 1'b1;
        w.dp.wr_addr = WA_ACC;
        w.dp.wr_data = WD_SI;
        w.dp.inc_n   = 1'b1;
        w.cond       = C_N_MORE;
        w.target     = PC_K1;
      end
      PC_G1: begin
        w.dp.rd_en   = 1'b1;
        w.dp.rd_addr = RA_IP1;
        w.dp.inc_i   = 1'b1;
      end
      PC_G2: begin
        w.dp.load_si = 1'b1;
        w.dp.j_add   = 1'b1;
        w.dp.rd_en   = 1'b1;
        w.dp.rd_addr = RA_JADD;
      end
      PC_G3: begin
        w.dp.wr_en   = 1'b1;
        w.dp.wr_addr = WA_I;
        w.dp.wr_data = WD_RDATA;
        w.dp.load_sj = 1'b1;
      end
      PC_G4: begin
        w.dp.wr_en   = 1'b1;
        w.dp.wr_addr = WA_J;
        w.dp.wr_data = WD_SI;
      end
      PC_G5: begin
        w.dp.rd_en   = 1'b1;
        w.dp.rd_addr = RA_SUM;
      end
      PC_G6: begin
        // drop this byte while the counter is nonzero
        w.dp.dec_drop = 1'b1;
        w.cond        = C_DROP_MORE;
        w.target      = PC_G1;
      end
      PC_G7: begin
        w.dp.emit = 1'b1;
        w.cond    = C_JUMP;
        w.target  = PC_IDLE;
      end
      default: begin
        w.cond   = C_JUMP;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: sv/rc4d_sequencer.sv
`default_nettype none
module rc4d_sequencer
  import rc4d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire start_t     start,
  input  wire dp_status_t status,
  output dp_ctrl_t        ctrl,
  output logic            busy
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          word;

  always_comb begin
    word = ucode(pc);
  end

  always_comb begin
    pc_next = pc + PC_W'(1);
    case (word.cond)
      C_NEXT: begin
        pc_next = pc + PC_W'(1);
      end
      C_JUMP: begin
        pc_next = word.target;
      end
      C_DISPATCH: begin
        if (start.go_sched) begin
          pc_next = PC_S0;
        end else if (start.go_gen) begin
          pc_next = PC_G1;
        end else begin
          pc_next = PC_IDLE;
        end
      end
      C_N_MORE: begin
        if (!status.n_last) begin
          pc_next = word.target;
        end
      end
      C_DROP_MORE: begin
        if (!status.dcnt_zero) begin
          pc_next = word.target;
        end
      end
      default: begin
        pc_next = PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl = word.dp;
  assign busy = (pc != PC_IDLE);

endmodule
`default_nettype wire

// File: sv/rc4d_datapath.sv
`default_nettype none
module rc4d_datapath
  import rc4d_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_ctrl_t             ctrl,
  input  wire logic [DROP_W-1:0]    drop_count,
  input  wire logic [KEY_CNT_W-1:0] key_count,
  input  wire logic                 key_we,
  input  wire logic [BYTE_W-1:0]    key_waddr,
  input  wire logic [BYTE_W-1:0]    key_wdata,
  output dp_status_t                status,
  output ks_t                       ks
);

  logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
  logic [BYTE_W-1:0] key_mem  [PERM_DEPTH];

  logic [BYTE_W-1:0] n;
  logic [BYTE_W-1:0] i;
  logic [BYTE_W-1:0] j;
  logic [BYTE_W-1:0] acc;
  logic [BYTE_W-1:0] k;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] sj;
  logic [DROP_W-1:0] dcnt;
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] kdata;

  logic [BYTE_W-1:0] acc_sum;
  logic [BYTE_W-1:0] j_sum;
  logic [BYTE_W-1:0] k_next;
  logic [BYTE_W-1:0] rd_addr;
  logic [BYTE_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  assign acc_sum = acc + rdata + kdata;
  assign j_sum   = j + rdata;
  // key index runs modulo the key length
  assign k_next  = (({1'b0, k} + KEY_CNT_W'(1)) == key_count) ? '0 : k + BYTE_W'(1);

  always_comb begin
    case (ctrl.rd_addr)
      RA_N:      rd_addr = n;
      RA_IP1:    rd_addr = i + BYTE_W'(1);
      RA_JADD:   rd_addr = j_sum;
      RA_ACCSUM: rd_addr = acc_sum;
      RA_SUM:    rd_addr = si + sj;
      default:   rd_addr = n;
    endcase
  end

  always_comb begin
    case (ctrl.wr_addr)
      WA_N:    wr_addr = n;
      WA_I:    wr_addr = i;
      WA_J:    wr_addr = j;
      WA_ACC:  wr_addr = acc;
      default: wr_addr = n;
    endcase
  end

  always_comb begin
    case (ctrl.wr_data)
      WD_N:     wr_data = n;
      WD_RDATA: wr_data = rdata;
      WD_SI:    wr_data = si;
      default:  wr_data = n;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rdata <= perm_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (ctrl.key_rd) begin
      kdata <= key_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n    <= '0;
      i    <= '0;
      j    <= '0;
      acc  <= '0;
      k    <= '0;
      dcnt <= '0;
    end else if (ctrl.clr_sched) begin
      n    <= '0;
      i    <= '0;
      j    <= '0;
      acc  <= '0;
      k    <= '0;
      dcnt <= drop_count;
    end else begin
      if (ctrl.inc_n) begin
        n <= n + BYTE_W'(1);
      end
      if (ctrl.inc_i) begin
        i <= i + BYTE_W'(1);
      end
      if (ctrl.j_add) begin
        j <= j_sum;
      end
      if (ctrl.acc_add) begin
        acc <= acc_sum;
      end
      if (ctrl.k_adv) begin
        k <= k_next;
      end
      if (ctrl.dec_drop && (dcnt != '0)) begin
        dcnt <= dcnt - DROP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_si) begin
      si <= rdata;
    end
    if (ctrl.load_sj) begin
      sj <= rdata;
    end
  end

  assign status.n_last    = (n == BYTE_W'(PERM_DEPTH - 1));
  assign status.dcnt_zero = (dcnt == '0);
  assign ks.valid         = ctrl.emit;
  assign ks.data          = rdata;

endmodule
`default_nettype wire

// File: sv/rc4_drop_stream_cipher.sv
// RC4 stream cipher with a keystream drop after each key schedule.
// Input channel (in_valid / in_stall): action 0 appends a key byte to the key
// store, action 1 carries a data byte; last_of_message closes a message.
// Output channel (out_valid / out_stall): one result per data byte, out_byte is
// the data byte XOR keystream; with an empty key the byte passes unchanged and
// key_error is set. Key bytes give no result.
// Configuration (cfg_valid / cfg_ready / cfg_data): drop_count, reset 256.
// One transaction is in flight at a time; a microcoded sequencer steps the
// permutation memory, which has one read and one write port.
// Key byte or empty-key data byte: handled without the sequencer.
// Data byte inside a message: six microsteps per keystream byte plus emit and
// dispatch; the emit step loads the result into the output register.
// First data byte of a message: a clear step, 256 identity fill steps, 4 * 256 key
// schedule steps and 6 * drop_count drop steps come before the keystream byte.
// Reset clears the key count, message state and output valid; drop_count
// returns to 256. While the receiver stalls a result, out_byte and key_error
// hold and in_stall stays high until the result is taken.
`default_nettype none
module rc4_drop_stream_cipher
  import rc4d_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire logic [BYTE_W-1:0] value,
  input  wire logic              last_of_message,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   key_error,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DROP_W-1:0] cfg_data
);

  logic [DROP_W-1:0]    drop_count;
  logic [KEY_CNT_W-1:0] key_count;
  logic                 scheduled;
  logic                 in_message;
  logic [BYTE_W-1:0]    data_value;

  logic                 busy;
  logic                 in_accept;
  logic                 out_take;
  logic                 key_accept;
  logic                 data_accept;
  logic                 err_accept;
  logic                 key_we;
  logic [BYTE_W-1:0]    key_waddr;
  start_t               start;
  dp_ctrl_t             ctrl;
  dp_status_t           status;
  ks_t                  ks;

  assign in_stall    = busy || (out_valid && out_stall);
  assign cfg_ready   = 1'b1;
  assign in_accept   = in_valid && !in_stall;
  assign out_take    = out_valid && !out_stall;
  assign key_accept  = in_accept && !action;
  assign data_accept = in_accept && action && (key_count != '0);
  assign err_accept  = in_accept && action && (key_count == '0);

  // a key byte after a used key starts a new key at entry zero
  assign key_we    = key_accept && (scheduled || (key_count < KEY_CNT_W'(MAX_KEY_BYTES)));
  assign key_waddr = scheduled ? '0 : key_count[BYTE_W-1:0];

  assign start.go_sched = data_accept && !in_message;
  assign start.go_gen   = data_accept && in_message;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_count <= DROP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      drop_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count  <= '0;
      scheduled  <= 1'b0;
      in_message <= 1'b0;
    end else if (key_accept) begin
      if (scheduled) begin
        key_count  <= KEY_CNT_W'(1);
        scheduled  <= 1'b0;
        in_message <= 1'b0;
      end else if (key_count < KEY_CNT_W'(MAX_KEY_BYTES)) begin
        key_count <= key_count + KEY_CNT_W'(1);
      end
    end else if (data_accept) begin
      scheduled  <= 1'b1;
      in_message <= !last_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept) begin
      data_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (err_accept || ks.valid) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (err_accept) begin
      out_byte  <= value;
      key_error <= 1'b1;
    end else if (ks.valid) begin
      out_byte  <= data_value ^ ks.data;
      key_error <= 1'b0;
    end
  end

  rc4d_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  rc4d_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .drop_count (drop_count),
    .key_count  (key_count),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (value),
    .status     (status),
    .ks         (ks)
  );

  // a keystream result never lands on a result still held in the output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ks.valid |-> !out_valid)
    else $error("keystream result while output register full");

  a_key_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= KEY_CNT_W'(MAX_KEY_BYTES))
    else $error("key count beyond key store");

  a_msg_sched: assert property (@(posedge clk) disable iff (rst)
    in_message |-> (scheduled && (key_count != '0)))
    else $error("open message without a scheduled key");

  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    data_accept |=> busy)
    else $error("data transaction did not start the sequencer");

  a_err_direct: assert property (@(posedge clk) disable iff (rst)
    err_accept |=> (out_valid && key_error && !busy))
    else $error("empty-key byte not passed through");

endmodule
`default_nettype wire

// File: verif/tb_rc4_drop_stream_cipher.sv
`timescale 1ns / 100ps
module tb_rc4_drop_stream_cipher;
  import rc4d_pkg::*;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              err;
  } cipher_out_t;

  // Tracks the cipher state and holds the ciphertext bytes still owed.
  class rc4_tracker;
    logic [BYTE_W-1:0] perm [PERM_DEPTH];
    logic [BYTE_W-1:0] keys [MAX_KEY_BYTES];
    int unsigned       key_cnt;
    logic [BYTE_W-1:0] ii, jj;
    bit                sched, in_msg;
    logic [DROP_W-1:0] drop;
    cipher_out_t       owed [$];
    int                bad;

    function new();
      key_cnt = 0;
      ii = '0;
      jj = '0;
      sched = 0;
      in_msg = 0;
      drop = DROP_RESET;
      bad = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function logic [BYTE_W-1:0] keystream_byte();
      logic [BYTE_W-1:0] t;
      ii = ii + 8'd1;
      jj = jj + perm[ii];
      t = perm[ii];
      perm[ii] = perm[jj];
      perm[jj] = t;
      t = perm[ii] + perm[jj];
      return perm[t];
    endfunction

    function void take_byte(logic act, logic [BYTE_W-1:0] v, logic lst);
      cipher_out_t       c;
      logic [BYTE_W-1:0] acc, t;
      int                n;
      if (act == ACT_KEY) begin
        // a key byte after data starts a new key
        if (sched) begin
          key_cnt = 0;
          sched = 0;
          in_msg = 0;
        end
        if (key_cnt < MAX_KEY_BYTES) begin
          keys[key_cnt] = v;
          key_cnt++;
        end
        return;
      end
      if (key_cnt == 0) begin
        c.data = v;
        c.err = 1'b1;
        owed.push_back(c);
        return;
      end
      if (!in_msg) begin
        for (n = 0; n < PERM_DEPTH; n++) perm[n] = n[BYTE_W-1:0];
        acc = '0;
        for (n = 0; n < PERM_DEPTH; n++) begin
          acc = acc + perm[n] + keys[n % key_cnt];
          t = perm[n];
          perm[n] = perm[acc];
          perm[acc] = t;
        end
        ii = '0;
        jj = '0;
        for (n = 0; n < drop; n++) void'(keystream_byte());
        in_msg = 1;
        sched = 1;
      end
      c.data = v ^ keystream_byte();
      c.err = 1'b0;
      owed.push_back(c);
      if (lst) in_msg = 0;
    endfunction

    function void compare_output(logic [BYTE_W-1:0] got, logic got_err);
      cipher_out_t c;
      if (owed.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%0t: unexpected result out_byte=%02h key_error=%0b", $realtime, got,
                   got_err);
        return;
      end
      c = owed.pop_front();
      if (got !== c.data || got_err !== c.err) begin
        bad++;
        if (bad <= 10)
          $display("%0t: mismatch out_byte exp %02h got %02h, key_error exp %0b got %0b",
                   $realtime, c.data, got, c.err, got_err);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              action;
  logic [BYTE_W-1:0] value;
  logic              last_of_message;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              key_error;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [DROP_W-1:0] cfg_data;

  rc4_tracker tracker = new();
  bit         calm = 0;
  int         data_sent;

  rc4_drop_stream_cipher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .value(value),
    .last_of_message(last_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .key_error(key_error),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 38);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.compare_output(out_byte, key_error);
  end

  task automatic push_byte(logic act, logic [BYTE_W-1:0] v, logic lst);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    value <= v;
    last_of_message <= lst;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(act, v, lst);
    if (act == ACT_DATA) data_sent++;
  endtask

  // hold until every result is in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_drop(logic [DROP_W-1:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.drop = d;
  endtask

  task automatic load_key(int len);
    for (int k = 0; k < len; k++)
      push_byte(ACT_KEY, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_message(int len, bit close);
    logic lst;
    for (int k = 0; k < len; k++) begin
      lst = (k == len - 1) ? close : ($urandom_range(0, 99) < 3);
      push_byte(ACT_DATA, BYTE_W'($urandom_range(0, 255)), lst);
    end
  endtask

  initial begin
    int          r, budget, maxlen, klen;
    bit          paused;
    logic [DROP_W-1:0] d;
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= 1'b0;
    value <= '0;
    last_of_message <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    data_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty key, then a short key with the reset drop count
    push_byte(ACT_DATA, 8'h00, 1'b0);
    push_byte(ACT_DATA, 8'hFF, 1'b1);
    push_byte(ACT_KEY, 8'h00, 1'b1);
    push_byte(ACT_KEY, 8'hFF, 1'b0);
    push_byte(ACT_KEY, 8'h5A, 1'b0);
    push_byte(ACT_DATA, 8'h00, 1'b0);
    push_byte(ACT_DATA, 8'hFF, 1'b0);
    push_byte(ACT_DATA, 8'hA5, 1'b1);
    push_byte(ACT_DATA, 8'h3C, 1'b0);
    // key byte in an open message drops the message
    push_byte(ACT_KEY, 8'h01, 1'b0);
    push_byte(ACT_DATA, 8'h80, 1'b1);
    set_drop('0);
    push_byte(ACT_DATA, 8'h11, 1'b1);
    push_byte(ACT_KEY, 8'h7F, 1'b1);
    push_byte(ACT_KEY, 8'h00, 1'b0);
    push_byte(ACT_DATA, 8'hFF, 1'b0);
    push_byte(ACT_DATA, 8'h00, 1'b1);
    set_drop(12'hFFF);
    push_byte(ACT_DATA, 8'h42, 1'b0);
    push_byte(ACT_DATA, 8'h24, 1'b1);
    set_drop(12'd1);
    push_byte(ACT_DATA, 8'h99, 1'b1);

    paused = 0;
    for (int p = 0; p < 10; p++) begin
      r = $urandom_range(0, 9);
      if (p == 4) d = 12'hFFF;
      else if (p == 7) d = '0;
      else if (r < 3) d = DROP_W'($urandom_range(1, 16));
      else if (r < 9) d = DROP_W'($urandom_range(17, 300));
      else d = DROP_W'($urandom_range(301, 600));
      set_drop(d);
      calm = (p == 2);
      maxlen = (p == 4) ? 80 : 24;
      budget = data_sent + 100;
      while (data_sent < budget) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          r = $urandom_range(0, 99);
          if (r < 85) klen = $urandom_range(1, 16);
          else if (r < 95) klen = $urandom_range(17, 255);
          else klen = $urandom_range(256, 270);
          load_key(klen);
        end else begin
          send_message($urandom_range(1, maxlen), $urandom_range(0, 99) >= 10);
        end
        if (p == 1 && !paused && data_sent > budget - 60) begin
          drain();
          paused = 1;
        end
      end
    end
    calm = 0;

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.bad == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: rc4_drop_stream_cipher.f
sv/rc4d_pkg.sv
sv/rc4d_sequencer.sv
sv/rc4d_datapath.sv
sv/rc4_drop_stream_cipher.sv
verif/tb_rc4_drop_stream_cipher.sv
